// File: hw/rtl/b64d_pkg.sv
// Shared types, constants and the symbol table for the Base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int unsigned TOTAL_WIDTH = 16;
  localparam int unsigned OUT_TOTAL_W = 16;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

  localparam logic [7:0] SYM_PAD   = 8'hFE;
  localparam logic [7:0] SYM_BAD   = 8'hFF;
  localparam logic [7:0] SYM_PLUS  = 8'd62;
  localparam logic [7:0] SYM_SLASH = 8'd63;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  // One queued job: up to three bytes, or a bare end-of-message status.
  typedef struct packed {
    logic [23:0]            word;
    logic [1:0]             nbytes;
    logic                   eom;
    status_e                status;
    logic [TOTAL_WIDTH-1:0] base;
  } entry_t;

  // Map a 7-bit character to its 6-bit value, the pad code or the illegal code.
  function automatic logic [7:0] sym_lookup(input logic [6:0] ch);
    logic [7:0] c;
    c = {1'b0, ch};
    unique case (ch) inside
      [7'h41:7'h5A]: sym_lookup = c - 8'd65;
      [7'h61:7'h7A]: sym_lookup = c - 8'd71;
      [7'h30:7'h39]: sym_lookup = c + 8'd4;
      7'h2B:         sym_lookup = SYM_PLUS;
      7'h2F:         sym_lookup = SYM_SLASH;
      7'h3D:         sym_lookup = SYM_PAD;
      default:       sym_lookup = SYM_BAD;
    endcase
  endfunction

endpackage

// File: hw/rtl/base64_stream_decoder.sv
// Usage notes:
// Base64 stream decoder. Input channel (in_valid_i/in_ready_o) takes one
// character per beat with an end-of-message flag; output channel
// (out_valid_o/out_ready_i) gives one result per beat: a decoded byte, or on
// end of message with nothing to emit, a bare status beat (has_byte_o low).
// last_o and status_o mark the final beat of a message.
// Throughput: one character per cycle unless the queue is full. A completed
// quad yields up to three bytes, which the emitter sends at one per cycle
// while out_ready_i is high; a stream never owes more beats than characters
// taken, so a free-running receiver never slows the input.
// A beat caused by a character shows on the output at the earliest the cycle
// after the character is accepted; the second and third bytes of a quad
// follow as the receiver takes them.
// A four-entry queue sits between the character front end and the emitter.
// When the receiver stalls the queue fills and in_ready_o drops once it holds
// four pending jobs; the output beat holds until taken.
// Reset clears all message state and empties the queue.
`timescale 1ns / 1ps
module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [15:0] decoded_total_o
);
  import b64d_pkg::*;

  logic   accept;
  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  b64d_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_char_i        (in_char_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .has_byte_o      (has_byte_o),
    .last_o          (last_o),
    .status_o        (status_o),
    .decoded_total_o (decoded_total_o)
  );

`ifndef SYNTHESIS
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> last_o)
    else $error("status beat without last");

  a_status_only_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && !has_byte_o)
    else $error("error status on a data beat");

  a_pop_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> out_valid_o && out_ready_i)
    else $error("queue popped without an output beat");

  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && has_byte_o && !last_o ##1 out_valid_o && has_byte_o
    |-> decoded_total_o != 16'd0)
    else $error("byte total reset inside a message");
`endif

endmodule

// File: hw/rtl/b64d_front.sv
// Front end: classifies characters, packs quads and builds queue entries.
`timescale 1ns / 1ps
module b64d_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_char_i,
  input  logic            end_of_message_i,
  output logic            push_o,
  output b64d_pkg::entry_t entry_o
);
  import b64d_pkg::*;

  logic [23:0]            acc_q, acc_d;
  logic [1:0]             pos_q, pos_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   err_q, err_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;

  logic [7:0]             sym;
  logic [23:0]            acc_a;
  logic [2:0]             cnt_a;
  logic                   err_a, err_b;
  logic [1:0]             nbytes;
  logic [1:0]             pos_n;
  logic [TOTAL_WIDTH:0]   sum;
  status_e                status;

  always_comb begin
    sym   = in_char_i[7] ? SYM_BAD : sym_lookup(in_char_i[6:0]);
    acc_a = acc_q;
    cnt_a = cnt_q;
    err_a = err_q;
    if (!err_q) begin
      if (sym == SYM_BAD) begin
        err_a = 1'b1;
      end else if (sym == SYM_PAD) begin
        acc_a = {acc_q[17:0], 6'b0};
      end else begin
        acc_a = {acc_q[17:0], sym[5:0]};
        cnt_a = cnt_q + 3'd1;
      end
    end

    err_b  = err_a;
    nbytes = 2'd0;
    if (pos_q == 2'd3 && !err_a) begin
      if (cnt_a < 3'd2) begin
        err_b = 1'b1;
      end else if (cnt_a > 3'd3) begin
        nbytes = 2'd3;
      end else begin
        nbytes = 2'(cnt_a - 3'd1);
      end
    end
    pos_n = pos_q + 2'd1;

    // Length check wins over a latched quad error.
    if (pos_n != 2'd0)  status = ST_LEN;
    else if (err_b)     status = ST_BAD;
    else                status = ST_OK;

    sum = {1'b0, total_q} + (TOTAL_WIDTH + 1)'(nbytes);

    push_o         = accept_i && (nbytes != 2'd0 || end_of_message_i);
    entry_o.word   = acc_a;
    entry_o.nbytes = nbytes;
    entry_o.eom    = end_of_message_i;
    entry_o.status = (nbytes == 2'd0) ? status : ST_OK;
    entry_o.base   = total_q;
  end

  always_comb begin
    acc_d   = acc_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    total_d = total_q;
    if (accept_i) begin
      if (end_of_message_i) begin
        acc_d   = '0;
        pos_d   = '0;
        cnt_d   = '0;
        err_d   = 1'b0;
        total_d = '0;
      end else begin
        pos_d   = pos_n;
        err_d   = err_b;
        acc_d   = (pos_q == 2'd3) ? 24'd0 : acc_a;
        cnt_d   = (pos_q == 2'd3) ? 3'd0 : cnt_a;
        total_d = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      total_q <= '0;
    end else begin
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      total_q <= total_d;
    end
  end

endmodule

// File: hw/rtl/b64d_queue.sv
// Small entry queue between the front end and the byte emitter.
`timescale 1ns / 1ps
module b64d_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64d_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output b64d_pkg::entry_t head_o
);
  import b64d_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop)      cnt_d = cnt_q + QCNT_W'(1);
    else if (!push_i && do_pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/b64d_back.sv
// Back end: walks the head entry and emits one result beat per cycle while the receiver is ready.
`timescale 1ns / 1ps
module b64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  b64d_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             has_byte_o,
  output logic             last_o,
  output logic [1:0]       status_o,
  output logic [15:0]      decoded_total_o
);
  import b64d_pkg::*;

  logic [1:0]             idx_q, idx_d;
  logic [1:0]             nres;
  logic                   final_beat;
  logic                   fire;
  logic [TOTAL_WIDTH:0]   tsum;
  logic [TOTAL_WIDTH-1:0] total;
  logic [4:0]             shift;

  always_comb begin
    nres       = (head_i.nbytes == 2'd0) ? 2'd1 : head_i.nbytes;
    final_beat = (idx_q == nres - 2'd1);
    fire       = valid_i && out_ready_i;
    pop_o      = fire && final_beat;
    idx_d      = idx_q;
    if (fire) idx_d = final_beat ? 2'd0 : idx_q + 2'd1;

    shift = 5'd16 - {idx_q, 3'b000};
    tsum  = {1'b0, head_i.base} + (TOTAL_WIDTH + 1)'(idx_q) + (TOTAL_WIDTH + 1)'(1);
    if (head_i.nbytes == 2'd0)        total = head_i.base;
    else if (tsum > {1'b0, TOTAL_MAX}) total = TOTAL_MAX;
    else                              total = tsum[TOTAL_WIDTH-1:0];

    out_valid_o     = valid_i;
    has_byte_o      = (head_i.nbytes != 2'd0);
    out_byte_o      = has_byte_o ? 8'(head_i.word >> shift) : 8'd0;
    last_o          = head_i.eom && final_beat;
    status_o        = last_o ? head_i.status : ST_OK;
    decoded_total_o = OUT_TOTAL_W'(total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
